// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that cons holds in the same cycle as ante
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/fjs_pkg.sv =====
// ----------------------------------------------------------------------------
// FCFS job scheduler package
// Field widths, codes and the queue entry type of the scheduler core.
// ----------------------------------------------------------------------------
package fjs_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int ID_W    = 8;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 32;

  // Input word: job_id, burst_length
  localparam int IN_DATA_W  = ID_W + BURST_W;
  // Result word: done_job_id and five time fields
  localparam int OUT_DATA_W = ID_W + 5 * TIME_W;

  // Item kind on the input tuser
  localparam logic FUNC_ARRIVAL = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  // Result kind on the output tuser
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_DROP = 1'b1;

  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  arrival;
    logic [ID_W-1:0]    id;
  } entry_t;

endpackage

// ===== rtl/fcfs_job_scheduler_core.sv =====
// An accepted input word reaches its result word through the input register,
// then the result register; items without a result end at the input register.
// Throughput: one item per cycle unless the result channel stalls, set by the
// single queue memory head read and 32-bit retire compare between the two registers.
// Reset (rst, synchronous, active high) empties the queue, idles the core and
// zeroes the time; queue memory contents are left as they are.
// ----------------------------------------------------------------------------
// FCFS job scheduler core
// Non-preemptive first-come-first-served scheduler driven by arrival and tick
// words; emits completion records and drop reports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcfs_job_scheduler_core #(
  parameter int QUEUE_DEPTH = fjs_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  // Input channel
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: job_id [7:0], burst_length [23:8]
  input  logic [fjs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: func [0]
  input  logic                         s_axis_tuser,
  // Result channel
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: done_job_id [7:0], arrival_stamp [39:8], response_delay [71:40],
  //        completion_stamp [103:72], turnaround [135:104], waiting [167:136]
  output logic [fjs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: status [0]
  output logic                         m_axis_tuser
);
  import fjs_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  // Input register
  logic               in_valid;
  logic               in_func;
  logic [ID_W-1:0]    in_id;
  logic [BURST_W-1:0] in_burst;

  // Queue storage and pointers
  entry_t             queue_mem [QUEUE_DEPTH];
  entry_t             head_data;
  entry_t             push_entry;
  logic [AW-1:0]      head;
  logic [AW-1:0]      tail;
  logic [CW-1:0]      count;
  logic [AW-1:0]      head_next;
  logic [AW-1:0]      tail_next;
  logic [CW-1:0]      count_next;

  // Running job and time
  logic               busy;
  logic [ID_W-1:0]    running_id;
  logic [TIME_W-1:0]  running_arrival;
  logic [BURST_W-1:0] running_burst;
  logic [TIME_W-1:0]  running_start;
  logic [TIME_W-1:0]  now;

  // Result register
  logic               out_valid;
  logic               out_status;
  logic [ID_W-1:0]    out_id;
  logic [TIME_W-1:0]  out_arrival;
  logic [TIME_W-1:0]  out_response;
  logic [TIME_W-1:0]  out_completion;
  logic [TIME_W-1:0]  out_turnaround;
  logic [TIME_W-1:0]  out_waiting;

  // Control
  logic               proceed;
  logic               is_tick;
  logic               full;
  logic               push;
  logic               drop;
  logic               retire;
  logic               dispatch;
  logic [TIME_W-1:0]  finish_time;
  logic [TIME_W-1:0]  resp_delay;

  // Advance the input word when the result slot is free or draining
  assign proceed       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || proceed;

  assign is_tick     = (in_func == FUNC_TICK);
  assign full        = (count == FULL_CNT);
  assign push        = proceed && !is_tick && !full;
  assign drop        = proceed && !is_tick && full;
  assign finish_time = running_start + TIME_W'(running_burst);
  assign retire      = proceed && is_tick && busy && (now == finish_time);
  assign dispatch    = proceed && is_tick && (!busy || retire) && (count != '0);
  // Waiting equals start minus arrival, since completion is start plus burst
  assign resp_delay  = running_start - running_arrival;

  assign push_entry.id      = in_id;
  assign push_entry.arrival = now;
  assign push_entry.burst   = in_burst;

  // Next queue pointers and fill count
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (dispatch) begin
      head_next  = (head == LAST_PTR) ? '0 : head + 1'b1;
      count_next = count - 1'b1;
    end
    if (push) begin
      tail_next  = (tail == LAST_PTR) ? '0 : tail + 1'b1;
      count_next = count + 1'b1;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_func  <= s_axis_tuser;
      in_id    <= s_axis_tdata[ID_W-1:0];
      in_burst <= s_axis_tdata[ID_W +: BURST_W];
    end
  end

  // Queue memory: write at tail, prefetch the next head with write bypass
  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[tail] <= push_entry;
    end
    if (push && (tail == head_next)) begin
      head_data <= push_entry;
    end else begin
      head_data <= queue_mem[head_next];
    end
  end

  // Queue pointers, running job and time
  always_ff @(posedge clk) begin
    if (rst) begin
      head            <= '0;
      tail            <= '0;
      count           <= '0;
      busy            <= 1'b0;
      running_id      <= '0;
      running_arrival <= '0;
      running_burst   <= '0;
      running_start   <= '0;
      now             <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (dispatch) begin
        busy            <= 1'b1;
        running_id      <= head_data.id;
        running_arrival <= head_data.arrival;
        running_burst   <= head_data.burst;
        running_start   <= now;
      end else if (retire) begin
        busy <= 1'b0;
      end
      if (proceed && is_tick) begin
        now <= now + 1'b1;
      end
    end
  end

  // Result register: load a completion record or a drop report
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= retire || drop;
    end
    if (drop) begin
      out_status     <= STATUS_DROP;
      out_id         <= in_id;
      out_arrival    <= now;
      out_response   <= '0;
      out_completion <= '0;
      out_turnaround <= '0;
      out_waiting    <= '0;
    end else if (retire) begin
      out_status     <= STATUS_DONE;
      out_id         <= running_id;
      out_arrival    <= running_arrival;
      out_response   <= resp_delay;
      out_completion <= now;
      out_turnaround <= now - running_arrival;
      out_waiting    <= resp_delay;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {out_waiting, out_turnaround, out_completion,
                          out_response, out_arrival, out_id};

  // Fill count never passes the queue depth
  `ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= FULL_CNT, "queue count overflow")
  // Empty or full queue has its pointers together
  `ASSERT_SAME(a_ptr_match, clk, rst,
               (count == '0) || (count == FULL_CNT), head == tail,
               "queue pointers disagree with count")
  // A processed tick advances time by one
  `ASSERT_NEXT(a_time_step, clk, rst,
               proceed && is_tick, now == $past(now) + 1'b1,
               "time did not advance on tick")

endmodule
